[hw/rtl/perceptron_sign_classifier_defines.svh]
// Assertion macros shared by the perceptron sign classifier RTL.
`ifndef PERCEPTRON_SIGN_CLASSIFIER_DEFINES_SVH
`define PERCEPTRON_SIGN_CLASSIFIER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define PSC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle.
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/psc_pkg.sv]
// Constants shared by the perceptron sign classifier.
package psc_pkg;

   localparam int POS_BITS   = 8;
   localparam int VALUE_BITS = 16;
   localparam int DIGIT_BITS = 4;
   localparam int CLASS_BITS = 4;
   localparam int MASK_BITS  = 11;
   localparam int MAP_BITS   = 64;

   localparam logic OP_WEIGHT = 1'b0;
   localparam logic OP_ANSWER = 1'b1;

   localparam logic [MAP_BITS-1:0] GROUP_MAP_RESET = 64'h6A98_7543_2550_0111;

   typedef logic [DIGIT_BITS-1:0] digit_type;

endpackage

[hw/rtl/psc_ram.sv]
// Generic simple dual-port RAM with registered read data.
module psc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 187
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/perceptron_sign_classifier.sv]
// Top level of the perceptron sign classifier with its shared multiply-accumulate sequencer.
//
//   channel   direction   transfer
//   req_      in          op, position, value, last
//   rsp_      out         class_index, from_network, sign_mask
//   csr_      in          group_map write, no handshake
//
// A weight write or an answer digit without last is taken only while the block is idle.
// An answer digit with last starts a sweep over every stored weight, read in turn
// through the single weight RAM read port feeding one multiply-accumulate unit.
// Reset is synchronous; it clears the answer digits and restores group_map.
// A result that is not taken holds the block in its final step; weight writes and
// digits are still accepted while an earlier result waits.
`include "perceptron_sign_classifier_defines.svh"

module perceptron_sign_classifier #(
   parameter int INPUT_COUNT = 16,
   parameter int CLASS_COUNT = 11,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic [psc_pkg::POS_BITS-1:0]          req_position,
   input  logic signed [psc_pkg::VALUE_BITS-1:0] req_value,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [psc_pkg::CLASS_BITS-1:0]        rsp_class_index,
   output logic                                  rsp_from_network,
   output logic [psc_pkg::MASK_BITS-1:0]         rsp_sign_mask,
   input  logic                                  csr_we,
   input  logic [psc_pkg::MAP_BITS-1:0]          csr_wdata
);

   localparam int ROW_STRIDE  = INPUT_COUNT + 1;
   localparam int STORE_DEPTH = CLASS_COUNT * ROW_STRIDE;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int IDX_BITS    = $clog2(INPUT_COUNT);
   localparam int COL_BITS    = $clog2(ROW_STRIDE);
   localparam int ROW_BITS    = $clog2(CLASS_COUNT);
   localparam int ACC_BITS    = WEIGHT_BITS + psc_pkg::DIGIT_BITS + COL_BITS + 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_WAIT   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [ADDR_BITS-1:0]            addr_ff, addr_in;
   logic [COL_BITS-1:0]             col_ff, col_in;
   logic [ROW_BITS-1:0]             row_ff, row_in;
   logic                            d_valid_ff, d_valid_in;
   logic [COL_BITS-1:0]             d_col_ff, d_col_in;
   logic [ROW_BITS-1:0]             d_row_ff, d_row_in;
   logic signed [ACC_BITS-1:0]      acc_ff, acc_in;
   logic [CLASS_COUNT-1:0]          mask_ff, mask_in;
   logic                            found_ff, found_in;
   logic [ROW_BITS-1:0]             chosen_ff, chosen_in;
   logic [IDX_BITS-1:0]             best_ff, best_in;
   psc_pkg::digit_type              best_val_ff, best_val_in;
   psc_pkg::digit_type              answer_ff [INPUT_COUNT];
   logic [psc_pkg::MAP_BITS-1:0]    group_map_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [psc_pkg::CLASS_BITS-1:0]  rsp_class_ff, rsp_class_in;
   logic                            rsp_net_ff, rsp_net_in;
   logic [psc_pkg::MASK_BITS-1:0]   rsp_mask_ff, rsp_mask_in;

   logic                            req_fire;
   logic                            start;
   logic                            answer_wr;
   logic [IDX_BITS-1:0]             answer_idx;
   logic                            weight_wr;
   logic [WEIGHT_BITS-1:0]          weight_rd;
   logic                            is_bias;
   psc_pkg::digit_type              digit;
   logic signed [WEIGHT_BITS+psc_pkg::DIGIT_BITS:0] product;
   logic signed [ACC_BITS-1:0]      term;
   logic signed [ACC_BITS-1:0]      sum;
   logic                            load_rsp;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign weight_wr  = req_fire && (req_op == psc_pkg::OP_WEIGHT)
                       && (32'(req_position) < STORE_DEPTH);
   assign answer_wr  = req_fire && (req_op == psc_pkg::OP_ANSWER)
                       && (32'(req_position) < INPUT_COUNT);
   assign answer_idx = IDX_BITS'(req_position);
   assign start      = req_fire && (req_op == psc_pkg::OP_ANSWER) && req_last;

   psc_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (weight_wr),
      .wr_addr (ADDR_BITS'(req_position)),
      .wr_data (WEIGHT_BITS'(req_value)),
      .rd_addr (addr_ff),
      .rd_data (weight_rd)
   );

   assign is_bias = (d_col_ff == COL_BITS'(INPUT_COUNT));
   assign digit   = is_bias ? '0 : answer_ff[d_col_ff[IDX_BITS-1:0]];
   assign product = $signed({1'b0, digit}) * $signed(weight_rd);
   assign term    = is_bias ? ACC_BITS'($signed(weight_rd)) : ACC_BITS'(product);
   assign sum     = ((d_col_ff == '0) ? '0 : acc_ff) + term;
   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      d_valid_in  = 1'b0;
      d_col_in    = col_ff;
      d_row_in    = row_ff;
      acc_in      = acc_ff;
      mask_in     = mask_ff;
      found_in    = found_ff;
      chosen_in   = chosen_ff;
      best_in     = best_ff;
      best_val_in = best_val_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               addr_in  = '0;
               col_in   = '0;
               row_in   = '0;
               mask_in  = '0;
               found_in = 1'b0;
            end
         end
         ST_RUN: begin
            d_valid_in = 1'b1;
            addr_in    = addr_ff + ADDR_BITS'(1);
            if (col_ff == COL_BITS'(INPUT_COUNT)) begin
               col_in = '0;
               row_in = row_ff + ROW_BITS'(1);
            end else begin
               col_in = col_ff + COL_BITS'(1);
            end
            if (addr_ff == ADDR_BITS'(STORE_DEPTH - 1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (d_valid_ff) begin
         acc_in = sum;
         if (is_bias && !sum[ACC_BITS-1]) begin
            mask_in[d_row_ff] = 1'b1;
            found_in          = 1'b1;
            chosen_in         = d_row_ff;
         end
         if ((d_row_ff == '0) && !is_bias) begin
            if (d_col_ff == '0) begin
               best_in     = '0;
               best_val_in = digit;
            end else if (digit > best_val_ff) begin
               best_in     = d_col_ff[IDX_BITS-1:0];
               best_val_in = digit;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_class_in = rsp_class_ff;
      rsp_net_in   = rsp_net_ff;
      rsp_mask_in  = rsp_mask_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_net_in   = found_ff;
         if (found_ff) begin
            rsp_class_in = psc_pkg::CLASS_BITS'(chosen_ff);
            rsp_mask_in  = psc_pkg::MASK_BITS'(mask_ff);
         end else begin
            rsp_class_in = group_map_ff[{best_ff, 2'b00} +: psc_pkg::CLASS_BITS];
            rsp_mask_in  = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         group_map_ff <= psc_pkg::GROUP_MAP_RESET;
         for (int i = 0; i < INPUT_COUNT; i++) begin
            answer_ff[IDX_BITS'(i)] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         d_valid_ff   <= d_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            group_map_ff <= csr_wdata;
         end
         if (answer_wr) begin
            answer_ff[answer_idx] <= psc_pkg::DIGIT_BITS'(req_value);
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      d_col_ff    <= d_col_in;
      d_row_ff    <= d_row_in;
      acc_ff      <= acc_in;
      mask_ff     <= mask_in;
      found_ff    <= found_in;
      chosen_ff   <= chosen_in;
      best_ff     <= best_in;
      best_val_ff <= best_val_in;
      rsp_class_ff <= rsp_class_in;
      rsp_net_ff   <= rsp_net_in;
      rsp_mask_ff  <= rsp_mask_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_class_index  = rsp_class_ff;
   assign rsp_from_network = rsp_net_ff;
   assign rsp_sign_mask    = rsp_mask_ff;

   `PSC_ASSERT_IMPLY(a_fallback_mask_clear, clock, reset,
      rsp_valid_ff && !rsp_net_ff, rsp_mask_ff == '0,
      "Fallback result carries a non-zero sign mask.")
   `PSC_ASSERT_IMPLY(a_wait_after_sweep, clock, reset,
      state_ff == ST_WAIT, $past(addr_ff) == ADDR_BITS'(STORE_DEPTH - 1),
      "Sweep ended before the last weight was read.")
   `PSC_ASSERT_IMPLY(a_result_from_finish, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH,
      "Result appeared outside the final step.")
   `PSC_ASSERT_NEXT(a_start_runs, clock, reset,
      start, state_ff == ST_RUN && addr_ff == '0,
      "Last answer transfer did not start the sweep.")

endmodule
